// ===== sv/prnp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prnp_pkg
// Shared types and constants for the point-to-rectangle nearest point block.
// ----------------------------------------------------------------------------
package prnp_pkg;

    localparam int CoordW   = 24;
    localparam int AxisW    = 48;
    localparam int ExtW     = 23;
    localparam int RootW    = 24;
    localparam int RadW     = 2 * RootW;
    localparam int GeomLat  = 8;
    localparam int Latency  = GeomLat + RootW + 1;
    localparam int AddrW    = 6;
    localparam int DataW    = 64;

    localparam logic [AxisW-1:0] HorizReset = 48'd16384;
    localparam logic [AxisW-1:0] VertReset  = 48'd1073741824;
    localparam logic [ExtW-1:0]  ExtReset   = 23'd256;

    typedef enum logic [2:0] {
        REG_CENTER_X    = 3'd0,
        REG_CENTER_Y    = 3'd1,
        REG_CENTER_Z    = 3'd2,
        REG_HORIZ_AXIS  = 3'd3,
        REG_VERT_AXIS   = 3'd4,
        REG_HALF_WIDTH  = 3'd5,
        REG_HALF_HEIGHT = 3'd6
    } t_reg;

    typedef struct packed {
        logic                     vld;
        logic                     sat;
        logic signed [CoordW-1:0] cx;
        logic signed [CoordW-1:0] cy;
        logic signed [CoordW-1:0] cz;
    } t_side;

endpackage

// ===== sv/prnp_geom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prnp_geom
// Eight-stage geometry pipeline: offset, projections, clamp, nearest point
// and squared distance ready for the root.
// ----------------------------------------------------------------------------
module prnp_geom
    import prnp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    input  logic signed [CoordW-1:0] i_qx,
    input  logic signed [CoordW-1:0] i_qy,
    input  logic signed [CoordW-1:0] i_qz,
    input  logic signed [CoordW-1:0] i_cx,
    input  logic signed [CoordW-1:0] i_cy,
    input  logic signed [CoordW-1:0] i_cz,
    input  logic [AxisW-1:0]         i_u,
    input  logic [AxisW-1:0]         i_v,
    input  logic [ExtW-1:0]          i_hw,
    input  logic [ExtW-1:0]          i_hh,
    output t_side                    o_side,
    output logic [RadW-1:0]          o_n
);

    logic [GeomLat-1:0] r_vld;

    logic signed [CoordW-1:0] w_c  [3];
    logic signed [CoordW-1:0] w_q  [3];
    logic signed [15:0]       w_uc [3];
    logic signed [15:0]       w_vc [3];

    logic signed [24:0] r_d  [3];
    logic signed [40:0] r_pu [3];
    logic signed [40:0] r_pv [3];
    logic signed [49:0] r_pd [3];
    logic signed [42:0] r_du, r_dv;
    logic signed [51:0] r_dd3, r_dd4, r_dd5, r_dd6;
    logic signed [29:0] r_bu, r_bv;
    logic signed [23:0] r_su4, r_sv4, r_su5, r_sv5;
    logic signed [31:0] r_tu, r_tv;
    logic signed [39:0] r_qu [3];
    logic signed [39:0] r_qv [3];
    logic signed [55:0] r_eu, r_ev;
    logic signed [40:0] r_p  [3];
    logic signed [57:0] r_sq;
    logic signed [28:0] r_pc [3];
    logic [RadW-1:0]    r_n;
    logic               r_sat;
    logic signed [CoordW-1:0] r_cl [3];

    logic signed [43:0] w_ru, w_rv;
    logic signed [29:0] n_bu, n_bv;
    logic signed [30:0] w_nu, w_nv, w_eu, w_ev;
    logic signed [30:0] n_su, n_sv;
    logic signed [41:0] w_rp [3];

    assign w_c[0] = i_cx;
    assign w_c[1] = i_cy;
    assign w_c[2] = i_cz;
    assign w_q[0] = i_qx;
    assign w_q[1] = i_qy;
    assign w_q[2] = i_qz;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_uc[i] = $signed(i_u[16*i +: 16]);
            w_vc[i] = $signed(i_v[16*i +: 16]);
            w_rp[i] = 42'(r_p[i]) + 42'sd8192;
        end
    end

    // round half up, then clamp to the extents
    always_comb begin
        w_ru = 44'(r_du) + 44'sd8192;
        w_rv = 44'(r_dv) + 44'sd8192;
        n_bu = w_ru[43:14];
        n_bv = w_rv[43:14];
        w_nu = -31'(n_bu);
        w_nv = -31'(n_bv);
        w_eu = $signed({8'd0, i_hw});
        w_ev = $signed({8'd0, i_hh});
        if (w_nu < -w_eu) begin
            n_su = -w_eu;
        end else if (w_nu > w_eu) begin
            n_su = w_eu;
        end else begin
            n_su = w_nu;
        end
        if (w_nv < -w_ev) begin
            n_sv = -w_ev;
        end else if (w_nv > w_ev) begin
            n_sv = w_ev;
        end else begin
            n_sv = w_nv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[GeomLat-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_d[i]  <= 25'(w_c[i]) - 25'(w_q[i]);
            r_pu[i] <= r_d[i] * w_uc[i];
            r_pv[i] <= r_d[i] * w_vc[i];
            r_pd[i] <= r_d[i] * r_d[i];
            r_qu[i] <= r_su4 * w_uc[i];
            r_qv[i] <= r_sv4 * w_vc[i];
            r_p[i]  <= 41'(r_qu[i]) + 41'(r_qv[i]);
            r_pc[i] <= 29'(w_c[i]) + 29'($signed(w_rp[i][41:14]));
            if (r_pc[i] > 29'sd8388607) begin
                r_cl[i] <= 24'sh7FFFFF;
            end else if (r_pc[i] < -29'sd8388608) begin
                r_cl[i] <= 24'sh800000;
            end else begin
                r_cl[i] <= r_pc[i][23:0];
            end
        end
        r_du  <= 43'(r_pu[0]) + 43'(r_pu[1]) + 43'(r_pu[2]);
        r_dv  <= 43'(r_pv[0]) + 43'(r_pv[1]) + 43'(r_pv[2]);
        r_dd3 <= 52'(r_pd[0]) + 52'(r_pd[1]) + 52'(r_pd[2]);
        r_bu  <= n_bu;
        r_bv  <= n_bv;
        r_su4 <= n_su[23:0];
        r_sv4 <= n_sv[23:0];
        r_dd4 <= r_dd3;
        r_tu  <= 32'(r_su4) + (32'(r_bu) <<< 1);
        r_tv  <= 32'(r_sv4) + (32'(r_bv) <<< 1);
        r_su5 <= r_su4;
        r_sv5 <= r_sv4;
        r_dd5 <= r_dd4;
        r_eu  <= r_su5 * r_tu;
        r_ev  <= r_sv5 * r_tv;
        r_dd6 <= r_dd5;
        r_sq  <= 58'(r_dd6) + 58'(r_eu) + 58'(r_ev);
        if (r_sq[57]) begin
            r_n   <= '0;
            r_sat <= 1'b0;
        end else begin
            r_n   <= r_sq[RadW-1:0];
            r_sat <= |r_sq[56:RadW];
        end
    end

    always_comb begin
        o_side.vld = r_vld[GeomLat-1];
        o_side.sat = r_sat;
        o_side.cx  = r_cl[0];
        o_side.cy  = r_cl[1];
        o_side.cz  = r_cl[2];
        o_n        = r_n;
    end

endmodule

// ===== sv/prnp_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prnp_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module prnp_isqrt
    import prnp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_side            i_side,
    input  logic [RadW-1:0]  i_n,
    output t_side            o_side,
    output logic [RootW-1:0] o_root
);

    logic [RadW-1:0] w_n  [RootW+1];
    logic [RadW-1:0] w_r  [RootW+1];
    t_side           w_sd [RootW+1];
    logic [RadW-1:0] r_n  [RootW];
    logic [RadW-1:0] r_r  [RootW];
    t_side           r_sd [RootW];

    assign w_n[0]  = i_n;
    assign w_r[0]  = '0;
    assign w_sd[0] = i_side;

    for (genvar k = 0; k < RootW; k++) begin : g_stage
        localparam logic [RadW-1:0] Bit = RadW'(1) << (2 * (RootW - 1 - k));
        logic [RadW-1:0] w_t;
        logic            w_ge;

        assign w_t  = w_r[k] + Bit;
        assign w_ge = w_n[k] >= w_t;

        always_ff @(posedge i_clk) begin
            if (w_ge) begin
                r_n[k] <= w_n[k] - w_t;
                r_r[k] <= (w_r[k] >> 1) + Bit;
            end else begin
                r_n[k] <= w_n[k];
                r_r[k] <= w_r[k] >> 1;
            end
            r_sd[k].sat <= w_sd[k].sat;
            r_sd[k].cx  <= w_sd[k].cx;
            r_sd[k].cy  <= w_sd[k].cy;
            r_sd[k].cz  <= w_sd[k].cz;
            if (!i_rst_n) begin
                r_sd[k].vld <= 1'b0;
            end else begin
                r_sd[k].vld <= w_sd[k].vld;
            end
        end

        assign w_n[k+1]  = r_n[k];
        assign w_r[k+1]  = r_r[k];
        assign w_sd[k+1] = r_sd[k];
    end

    assign o_side = w_sd[RootW];
    assign o_root = w_r[RootW][RootW-1:0];

endmodule

// ===== sv/point_rectangle_nearest_point_top.sv =====
// Geometry, root, output register to o_valid; one query accepted every cycle.
// Throughput is set by the fully pipelined geometry and one-bit-per-stage root.
// busy stays low; results are strobed once on o_valid and cannot be stalled.
// Synchronous active-low reset clears the pipeline and restores the registers.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_rectangle_nearest_point_top
// Nearest point on an oriented rectangle and distance to it, APB configured.
// ----------------------------------------------------------------------------
module point_rectangle_nearest_point_top
    import prnp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [AddrW-1:0]         paddr,
    input  logic [DataW-1:0]         pwdata,
    output logic [DataW-1:0]         prdata,
    output logic                     pready,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [CoordW-1:0] i_query_x,
    input  logic signed [CoordW-1:0] i_query_y,
    input  logic signed [CoordW-1:0] i_query_z,
    output logic                     o_valid,
    output logic signed [CoordW-1:0] o_closest_x,
    output logic signed [CoordW-1:0] o_closest_y,
    output logic signed [CoordW-1:0] o_closest_z,
    output logic [RootW-1:0]         o_separation
);

    logic signed [CoordW-1:0] r_cx, r_cy, r_cz;
    logic [AxisW-1:0]         r_u, r_v;
    logic [ExtW-1:0]          r_hw, r_hh;

    logic                     r_valid;
    logic signed [CoordW-1:0] r_ox, r_oy, r_oz;
    logic [RootW-1:0]         r_sep;

    t_side            w_gside, w_rside;
    logic [RadW-1:0]  w_n;
    logic [RootW-1:0] w_root;
    logic             w_wr;
    t_reg             w_reg;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_reg  = t_reg'(paddr[AddrW-1:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
            r_cz <= '0;
            r_u  <= HorizReset;
            r_v  <= VertReset;
            r_hw <= ExtReset;
            r_hh <= ExtReset;
        end else if (w_wr) begin
            case (w_reg)
                REG_CENTER_X:    r_cx <= pwdata[CoordW-1:0];
                REG_CENTER_Y:    r_cy <= pwdata[CoordW-1:0];
                REG_CENTER_Z:    r_cz <= pwdata[CoordW-1:0];
                REG_HORIZ_AXIS:  r_u  <= pwdata[AxisW-1:0];
                REG_VERT_AXIS:   r_v  <= pwdata[AxisW-1:0];
                REG_HALF_WIDTH:  r_hw <= pwdata[ExtW-1:0];
                REG_HALF_HEIGHT: r_hh <= pwdata[ExtW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_CENTER_X:    prdata = DataW'(unsigned'(r_cx));
            REG_CENTER_Y:    prdata = DataW'(unsigned'(r_cy));
            REG_CENTER_Z:    prdata = DataW'(unsigned'(r_cz));
            REG_HORIZ_AXIS:  prdata = DataW'(r_u);
            REG_VERT_AXIS:   prdata = DataW'(r_v);
            REG_HALF_WIDTH:  prdata = DataW'(r_hw);
            REG_HALF_HEIGHT: prdata = DataW'(r_hh);
            default:         prdata = '0;
        endcase
    end

    prnp_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start && !busy),
        .i_qx    (i_query_x),
        .i_qy    (i_query_y),
        .i_qz    (i_query_z),
        .i_cx    (r_cx),
        .i_cy    (r_cy),
        .i_cz    (r_cz),
        .i_u     (r_u),
        .i_v     (r_v),
        .i_hw    (r_hw),
        .i_hh    (r_hh),
        .o_side  (w_gside),
        .o_n     (w_n)
    );

    prnp_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (w_gside),
        .i_n     (w_n),
        .o_side  (w_rside),
        .o_root  (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_rside.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ox  <= w_rside.cx;
        r_oy  <= w_rside.cy;
        r_oz  <= w_rside.cz;
        r_sep <= w_rside.sat ? {RootW{1'b1}} : w_root;
    end

    assign o_valid      = r_valid;
    assign o_closest_x  = r_ox;
    assign o_closest_y  = r_oy;
    assign o_closest_z  = r_oz;
    assign o_separation = r_sep;

`ifndef SYNTH
    a_beat_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, Latency))
        else $error("result beat without a matching query");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

    a_sat_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rside.vld && w_rside.sat |=> o_separation == {RootW{1'b1}})
        else $error("separation not saturated");
`endif

endmodule
